/* rtl/lci_pkg.sv */
// ---------------------------------------------------------------------------
// lci_pkg: shared types and widths for the line/circle intersection block
// Field structs, derived arithmetic widths and register/hit codes.
// ---------------------------------------------------------------------------
package lci_pkg;

   localparam int COORD_BITS   = 24;
   localparam int RAD_BITS     = COORD_BITS - 1;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;
   localparam int A_BITS       = 2 * COORD_BITS + 1;
   localparam int BETA_BITS    = 2 * COORD_BITS + 2;
   localparam int CRS_BITS     = 2 * COORD_BITS + 1;
   localparam int R2_BITS      = 2 * RAD_BITS;
   localparam int SPLIT_BITS   = COORD_BITS + 1;
   localparam int Q_BITS       = 4 * COORD_BITS + 3;
   localparam int ROOT_BITS    = 2 * COORD_BITS + 1;
   localparam int RADIC_BITS   = 2 * ROOT_BITS;
   localparam int NUM_BITS     = 2 * COORD_BITS + 4;
   localparam int NMAG_BITS    = 2 * COORD_BITS + 3;
   localparam int PMAG_BITS    = NMAG_BITS + COORD_BITS;
   localparam int DEN_BITS     = 2 * COORD_BITS + 2;
   localparam int QUO_BITS     = COORD_BITS + 3;
   localparam int HIT_BITS     = QUO_BITS + 2;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_VALID  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CX     = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CY     = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RADIUS = 2'd3;

   localparam logic [1:0] HITS_NONE = 2'd0;
   localparam logic [1:0] HITS_ONE  = 2'd1;
   localparam logic [1:0] HITS_TWO  = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      logic [1:0] hit_count;
      coord_type  first_x;
      coord_type  first_y;
      coord_type  second_x;
      coord_type  second_y;
      logic       saturated;
   } rsp_type;

   typedef struct packed {
      logic                circle_valid;
      coord_type           centre_x;
      coord_type           centre_y;
      logic [RAD_BITS-1:0] radius;
   } cfg_type;

   // values that ride alongside the root extraction
   typedef struct packed {
      logic [1:0]                   hit_count;
      coord_type                    start_x;
      coord_type                    start_y;
      logic signed [DIFF_BITS-1:0]  dx;
      logic signed [DIFF_BITS-1:0]  dy;
      logic signed [BETA_BITS-1:0]  beta;
      logic [A_BITS-1:0]            a;
   } side_type;

endpackage

/* rtl/lci_front.sv */
// ---------------------------------------------------------------------------
// lci_front: quadratic coefficients and discriminant
// Six stages: deltas, products, sums, split products, partial sums, and
// the discriminant D = 4 * (a*r^2 - cross^2) with the hit count.
// ---------------------------------------------------------------------------
module lci_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                valid_in,
   input  lci_pkg::req_type                    req,
   input  lci_pkg::cfg_type                    cfg,
   output logic                                valid_out,
   output lci_pkg::side_type                   side_out,
   output logic [lci_pkg::RADIC_BITS-1:0]      radicand
);
   import lci_pkg::*;

   localparam int H = SPLIT_BITS;

   logic [5:0] vld_ff;

   logic signed [DIFF_BITS-1:0] dx1_ff, dy1_ff, px1_ff, py1_ff;
   coord_type                   sx1_ff, sy1_ff;
   logic [RAD_BITS-1:0]         r1_ff;
   logic                        ok1_ff;

   logic signed [PROD_BITS-1:0] dxdx2_ff, dydy2_ff, dxpx2_ff, dypy2_ff, dxpy2_ff, dypx2_ff;
   logic [R2_BITS-1:0]          r22_ff;
   logic signed [DIFF_BITS-1:0] dx2_ff, dy2_ff;
   coord_type                   sx2_ff, sy2_ff;
   logic                        ok2_ff;

   logic signed [PROD_BITS-1:0] asum, crs;
   side_type                    side3_ff;
   logic [CRS_BITS-1:0]         cm3_ff;
   logic [R2_BITS-1:0]          r23_ff;
   logic                        live3_ff;

   logic [A_BITS-H+R2_BITS-H-1:0] ahh4_ff;
   logic [A_BITS-H+H-1:0]         ahl4_ff;
   logic [H+R2_BITS-H-1:0]        alh4_ff;
   logic [2*H-1:0]                all4_ff;
   logic [2*(CRS_BITS-H)-1:0]     chh4_ff;
   logic [CRS_BITS-H+H-1:0]       chl4_ff;
   logic [2*H-1:0]                cll4_ff;
   side_type                      side4_ff;
   logic                          live4_ff;

   logic [Q_BITS-1:0] ar5_ff, cr5_ff;
   side_type          side5_ff;
   logic              live5_ff;

   logic signed [Q_BITS-1:0] q;
   logic [1:0]               count;
   side_type                 side6_ff;
   logic [RADIC_BITS-1:0]    rad6_ff;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[4:0], valid_in};
      end
   end

   // stage 1: direction and offset from centre
   always_ff @(posedge clock) begin
      dx1_ff <= DIFF_BITS'(req.end_x) - DIFF_BITS'(req.start_x);
      dy1_ff <= DIFF_BITS'(req.end_y) - DIFF_BITS'(req.start_y);
      px1_ff <= DIFF_BITS'(req.start_x) - DIFF_BITS'(cfg.centre_x);
      py1_ff <= DIFF_BITS'(req.start_y) - DIFF_BITS'(cfg.centre_y);
      sx1_ff <= req.start_x;
      sy1_ff <= req.start_y;
      r1_ff  <= cfg.radius;
      ok1_ff <= cfg.circle_valid;
   end

   // stage 2: pairwise products
   always_ff @(posedge clock) begin
      dxdx2_ff <= dx1_ff * dx1_ff;
      dydy2_ff <= dy1_ff * dy1_ff;
      dxpx2_ff <= dx1_ff * px1_ff;
      dypy2_ff <= dy1_ff * py1_ff;
      dxpy2_ff <= dx1_ff * py1_ff;
      dypx2_ff <= dy1_ff * px1_ff;
      r22_ff   <= r1_ff * r1_ff;
      dx2_ff   <= dx1_ff;
      dy2_ff   <= dy1_ff;
      sx2_ff   <= sx1_ff;
      sy2_ff   <= sy1_ff;
      ok2_ff   <= ok1_ff;
   end

   // stage 3: a, half of b, and the cross product magnitude
   always_comb begin
      asum = dxdx2_ff + dydy2_ff;
      crs  = dxpy2_ff - dypx2_ff;
   end

   always_ff @(posedge clock) begin
      side3_ff.hit_count <= HITS_NONE;
      side3_ff.start_x   <= sx2_ff;
      side3_ff.start_y   <= sy2_ff;
      side3_ff.dx        <= dx2_ff;
      side3_ff.dy        <= dy2_ff;
      side3_ff.beta      <= BETA_BITS'(dxpx2_ff + dypy2_ff);
      side3_ff.a         <= A_BITS'(asum);
      cm3_ff             <= CRS_BITS'(crs[PROD_BITS-1] ? -crs : crs);
      r23_ff             <= r22_ff;
      live3_ff           <= ok2_ff && (asum != '0);
   end

   // stage 4: split products of a*r^2 and cross^2
   always_ff @(posedge clock) begin
      ahh4_ff  <= side3_ff.a[A_BITS-1:H] * r23_ff[R2_BITS-1:H];
      ahl4_ff  <= side3_ff.a[A_BITS-1:H] * r23_ff[H-1:0];
      alh4_ff  <= side3_ff.a[H-1:0] * r23_ff[R2_BITS-1:H];
      all4_ff  <= side3_ff.a[H-1:0] * r23_ff[H-1:0];
      chh4_ff  <= cm3_ff[CRS_BITS-1:H] * cm3_ff[CRS_BITS-1:H];
      chl4_ff  <= cm3_ff[CRS_BITS-1:H] * cm3_ff[H-1:0];
      cll4_ff  <= cm3_ff[H-1:0] * cm3_ff[H-1:0];
      side4_ff <= side3_ff;
      live4_ff <= live3_ff;
   end

   // stage 5: recombine partial products
   always_ff @(posedge clock) begin
      ar5_ff   <= (Q_BITS'(ahh4_ff) << (2 * H)) + (Q_BITS'(ahl4_ff) << H)
                + (Q_BITS'(alh4_ff) << H) + Q_BITS'(all4_ff);
      cr5_ff   <= (Q_BITS'(chh4_ff) << (2 * H)) + (Q_BITS'(chl4_ff) << (H + 1))
                + Q_BITS'(cll4_ff);
      side5_ff <= side4_ff;
      live5_ff <= live4_ff;
   end

   // stage 6: quarter discriminant, hit count
   always_comb begin
      q = ar5_ff - cr5_ff;
      if (!live5_ff || q[Q_BITS-1]) begin
         count = HITS_NONE;
      end else if (q == '0) begin
         count = HITS_ONE;
      end else begin
         count = HITS_TWO;
      end
   end

   always_ff @(posedge clock) begin
      side6_ff <= {count, side5_ff.start_x, side5_ff.start_y, side5_ff.dx,
                   side5_ff.dy, side5_ff.beta, side5_ff.a};
      rad6_ff  <= q[Q_BITS-1] ? '0 : {q[RADIC_BITS-3:0], 2'b00};
   end

   assign valid_out = vld_ff[5];
   assign side_out  = side6_ff;
   assign radicand  = rad6_ff;

endmodule

/* rtl/lci_sqrt.sv */
// ---------------------------------------------------------------------------
// lci_sqrt: pipelined floored square root
// One root bit per stage, ROOT_W stages, remainder method.
// ---------------------------------------------------------------------------
module lci_sqrt #(
   parameter int ROOT_W = lci_pkg::ROOT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_in,
   input  logic [2*ROOT_W-1:0]   radicand,
   output logic                  valid_out,
   output logic [ROOT_W-1:0]     root
);
   localparam int REM_W = ROOT_W + 2;

   logic [ROOT_W-1:0]   vld_ff;
   logic [REM_W-1:0]    rem_ff   [ROOT_W];
   logic [REM_W-1:0]    rem_in   [ROOT_W];
   logic [ROOT_W-1:0]   root_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_in  [ROOT_W];
   logic [2*ROOT_W-1:0] rad_ff   [ROOT_W];
   logic [2*ROOT_W-1:0] rad_in   [ROOT_W];

   // one trial subtraction per stage
   always_comb begin
      logic [REM_W-1:0]    rem_s;
      logic [ROOT_W-1:0]   root_s;
      logic [2*ROOT_W-1:0] rad_s;
      logic [REM_W+1:0]    cat;
      logic [REM_W+1:0]    trial;
      for (int i = 0; i < ROOT_W; i++) begin
         if (i == 0) begin
            rem_s  = '0;
            root_s = '0;
            rad_s  = radicand;
         end else begin
            rem_s  = rem_ff[i-1];
            root_s = root_ff[i-1];
            rad_s  = rad_ff[i-1];
         end
         cat   = {rem_s, rad_s[2*ROOT_W-1 -: 2]};
         trial = (REM_W+2)'({root_s, 2'b01});
         if (cat >= trial) begin
            rem_in[i]  = REM_W'(cat - trial);
            root_in[i] = {root_s[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[i]  = REM_W'(cat);
            root_in[i] = {root_s[ROOT_W-2:0], 1'b0};
         end
         rad_in[i] = rad_s << 2;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ROOT_W-2:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ROOT_W; i++) begin
         rem_ff[i]  <= rem_in[i];
         root_ff[i] <= root_in[i];
         rad_ff[i]  <= rad_in[i];
      end
   end

   assign valid_out = vld_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];

endmodule

/* rtl/lci_div.sv */
// ---------------------------------------------------------------------------
// lci_div: pipelined unsigned restoring divider
// One quotient bit per stage; the numerator's upper part must be below den.
// ---------------------------------------------------------------------------
module lci_div #(
   parameter int NUM_W = lci_pkg::PMAG_BITS,
   parameter int DEN_W = lci_pkg::DEN_BITS,
   parameter int QUO_W = lci_pkg::QUO_BITS
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);
   logic [DEN_W-1:0] rem_ff  [QUO_W];
   logic [DEN_W-1:0] rem_in  [QUO_W];
   logic [DEN_W-1:0] den_ff  [QUO_W];
   logic [QUO_W-1:0] low_ff  [QUO_W];
   logic [QUO_W-1:0] low_in  [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [QUO_W-1:0] quo_in  [QUO_W];
   logic [DEN_W-1:0] den_src [QUO_W];

   // one compare and subtract per stage
   always_comb begin
      logic [DEN_W-1:0] rem_s;
      logic [QUO_W-1:0] low_s;
      logic [QUO_W-1:0] quo_s;
      logic [DEN_W:0]   cat;
      for (int i = 0; i < QUO_W; i++) begin
         if (i == 0) begin
            rem_s      = DEN_W'(num[NUM_W-1:QUO_W]);
            low_s      = num[QUO_W-1:0];
            quo_s      = '0;
            den_src[i] = den;
         end else begin
            rem_s      = rem_ff[i-1];
            low_s      = low_ff[i-1];
            quo_s      = quo_ff[i-1];
            den_src[i] = den_ff[i-1];
         end
         cat = {rem_s, low_s[QUO_W-1]};
         if (cat >= {1'b0, den_src[i]}) begin
            rem_in[i] = DEN_W'(cat - {1'b0, den_src[i]});
            quo_in[i] = {quo_s[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[i] = DEN_W'(cat);
            quo_in[i] = {quo_s[QUO_W-2:0], 1'b0};
         end
         low_in[i] = low_s << 1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUO_W; i++) begin
         rem_ff[i] <= rem_in[i];
         low_ff[i] <= low_in[i];
         quo_ff[i] <= quo_in[i];
         den_ff[i] <= den_src[i];
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

/* rtl/lci_back.sv */
// ---------------------------------------------------------------------------
// lci_back: hit points from the root
// Numerators, split products, four pipelined dividers, then offset,
// saturation and the result register.
// ---------------------------------------------------------------------------
module lci_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           valid_in,
   input  logic [lci_pkg::ROOT_BITS-1:0]  root,
   input  lci_pkg::side_type              side,
   output logic                           rsp_valid,
   output lci_pkg::rsp_type               rsp
);
   import lci_pkg::*;

   localparam int H      = SPLIT_BITS;
   localparam int LO_W   = H + COORD_BITS;
   localparam int HI_W   = NMAG_BITS - H + COORD_BITS;
   localparam int PIPE_W = QUO_BITS + 4;

   localparam logic signed [HIT_BITS-1:0] CMAX =
      {{(HIT_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [HIT_BITS-1:0] CMIN =
      {{(HIT_BITS-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      logic [1:0] hit_count;
      coord_type  start_x;
      coord_type  start_y;
      logic [3:0] neg;
   } trk_type;

   logic [PIPE_W-1:0] vld_ff;

   logic signed [NUM_BITS-1:0] nb, np, nm, rs;
   logic [NMAG_BITS-1:0]       mp1_ff, mm1_ff;
   logic                       sp1_ff, sm1_ff;
   logic [COORD_BITS-1:0]      mdx1_ff, mdy1_ff;
   logic                       sdx1_ff, sdy1_ff;
   logic [DEN_BITS-1:0]        den1_ff, den2_ff, den3_ff;
   trk_type                    trk1_ff, trk2_ff, trk3_ff;

   logic [NMAG_BITS-1:0]  mag  [4];
   logic [COORD_BITS-1:0] dmag [4];
   logic [3:0]            neg;
   logic [LO_W-1:0]       lo2_ff   [4];
   logic [HI_W-1:0]       hi2_ff   [4];
   logic [PMAG_BITS-1:0]  prod3_ff [4];
   logic [QUO_BITS-1:0]   quo      [4];

   trk_type dly_ff [QUO_BITS];

   logic signed [HIT_BITS-1:0] off [4];
   logic signed [HIT_BITS-1:0] hit [4];
   coord_type                  crd [4];
   logic [3:0]                 clip;
   logic [3:0]                 shown;
   rsp_type                    rsp_in;
   rsp_type                    rsp_ff;
   trk_type                    fin;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[PIPE_W-2:0], valid_in};
      end
   end

   // stage 1: numerators -b +/- s as sign and magnitude
   always_comb begin
      rs = NUM_BITS'(root);
      nb = -(NUM_BITS'(side.beta) <<< 1);
      np = nb + rs;
      nm = nb - rs;
   end

   always_ff @(posedge clock) begin
      mp1_ff            <= NMAG_BITS'(np[NUM_BITS-1] ? -np : np);
      mm1_ff            <= NMAG_BITS'(nm[NUM_BITS-1] ? -nm : nm);
      sp1_ff            <= np[NUM_BITS-1];
      sm1_ff            <= nm[NUM_BITS-1];
      mdx1_ff           <= COORD_BITS'(side.dx[DIFF_BITS-1] ? -side.dx : side.dx);
      mdy1_ff           <= COORD_BITS'(side.dy[DIFF_BITS-1] ? -side.dy : side.dy);
      sdx1_ff           <= side.dx[DIFF_BITS-1];
      sdy1_ff           <= side.dy[DIFF_BITS-1];
      den1_ff           <= {side.a, 1'b0};
      trk1_ff.hit_count <= side.hit_count;
      trk1_ff.start_x   <= side.start_x;
      trk1_ff.start_y   <= side.start_y;
      trk1_ff.neg       <= '0;
   end

   // stage 2: split products, lanes are +x, +y, -x, -y
   always_comb begin
      mag[0]  = mp1_ff;
      mag[1]  = mp1_ff;
      mag[2]  = mm1_ff;
      mag[3]  = mm1_ff;
      dmag[0] = mdx1_ff;
      dmag[1] = mdy1_ff;
      dmag[2] = mdx1_ff;
      dmag[3] = mdy1_ff;
      neg     = {sm1_ff ^ sdy1_ff, sm1_ff ^ sdx1_ff, sp1_ff ^ sdy1_ff, sp1_ff ^ sdx1_ff};
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         lo2_ff[k] <= mag[k][H-1:0] * dmag[k];
         hi2_ff[k] <= mag[k][NMAG_BITS-1:H] * dmag[k];
      end
      den2_ff <= den1_ff;
      trk2_ff <= {trk1_ff.hit_count, trk1_ff.start_x, trk1_ff.start_y, neg};
   end

   // stage 3: recombine products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         prod3_ff[k] <= (PMAG_BITS'(hi2_ff[k]) << H) + PMAG_BITS'(lo2_ff[k]);
      end
      den3_ff <= den2_ff;
      trk3_ff <= trk2_ff;
   end

   // divide each lane by 2a
   for (genvar k = 0; k < 4; k++) begin : g_lane
      lci_div #(
         .NUM_W (PMAG_BITS),
         .DEN_W (DEN_BITS),
         .QUO_W (QUO_BITS)
      ) u_div (
         .clock (clock),
         .num   (prod3_ff[k]),
         .den   (den3_ff),
         .quo   (quo[k])
      );
   end

   // hold lane context beside the dividers
   always_ff @(posedge clock) begin
      dly_ff[0] <= trk3_ff;
      for (int i = 1; i < QUO_BITS; i++) begin
         dly_ff[i] <= dly_ff[i-1];
      end
   end

   // offset from start, clip to range, drop unreported hits
   always_comb begin
      fin = dly_ff[QUO_BITS-1];
      for (int k = 0; k < 4; k++) begin
         off[k] = HIT_BITS'(quo[k]);
         if (fin.neg[k]) begin
            off[k] = -off[k];
         end
         if (k == 0 || k == 2) begin
            hit[k] = HIT_BITS'(fin.start_x) + off[k];
         end else begin
            hit[k] = HIT_BITS'(fin.start_y) + off[k];
         end
         if (hit[k] > CMAX) begin
            crd[k]  = CMAX[COORD_BITS-1:0];
            clip[k] = 1'b1;
         end else if (hit[k] < CMIN) begin
            crd[k]  = CMIN[COORD_BITS-1:0];
            clip[k] = 1'b1;
         end else begin
            crd[k]  = hit[k][COORD_BITS-1:0];
            clip[k] = 1'b0;
         end
      end
      shown[0] = (fin.hit_count != HITS_NONE);
      shown[1] = shown[0];
      shown[2] = (fin.hit_count == HITS_TWO);
      shown[3] = shown[2];
      rsp_in.hit_count = fin.hit_count;
      rsp_in.first_x   = shown[0] ? crd[0] : '0;
      rsp_in.first_y   = shown[1] ? crd[1] : '0;
      rsp_in.second_x  = shown[2] ? crd[2] : '0;
      rsp_in.second_y  = shown[3] ? crd[3] : '0;
      rsp_in.saturated = |(clip & shown);
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = vld_ff[PIPE_W-1];
   assign rsp       = rsp_ff;

endmodule

/* rtl/line_circle_intersection.sv */
// ---------------------------------------------------------------------------
// line_circle_intersection: line through two points against a fixed circle
// Fully pipelined; reports 0, 1 or 2 hit points per line item.
// ---------------------------------------------------------------------------
//  channel  ports                         direction  handshake
//  request  start, busy, req_data         in         start & !busy
//  result   rsp_valid, rsp_data           out        one-cycle strobe
//  config   csr_we, csr_index, csr_wdata  in         write on csr_we
//
//  One item is taken every cycle; busy stays low.
//  The root pipeline (one bit per stage) and the divider pipeline (one bit
//  per stage) make up most of the latency.
//  Synchronous reset clears the valid chain and the circle registers.
//  The receiver takes each result in the cycle it appears; nothing stalls.
// ---------------------------------------------------------------------------
module line_circle_intersection (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  lci_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output lci_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [lci_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [lci_pkg::COORD_BITS-1:0]      csr_wdata
);
   import lci_pkg::*;

   cfg_type               cfg_ff;
   logic                  f_valid;
   side_type              f_side;
   logic [RADIC_BITS-1:0] f_rad;
   logic                  s_valid;
   logic [ROOT_BITS-1:0]  s_root;
   side_type              side_dly_ff [ROOT_BITS];

   // circle registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VALID:  cfg_ff.circle_valid <= csr_wdata[0];
            CSR_CX:     cfg_ff.centre_x     <= csr_wdata;
            CSR_CY:     cfg_ff.centre_y     <= csr_wdata;
            CSR_RADIUS: cfg_ff.radius       <= csr_wdata[RAD_BITS-1:0];
            default:    cfg_ff              <= cfg_ff;
         endcase
      end
   end

   assign busy = 1'b0;

   lci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (start && !busy),
      .req       (req_data),
      .cfg       (cfg_ff),
      .valid_out (f_valid),
      .side_out  (f_side),
      .radicand  (f_rad)
   );

   lci_sqrt #(
      .ROOT_W (ROOT_BITS)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (f_valid),
      .radicand  (f_rad),
      .valid_out (s_valid),
      .root      (s_root)
   );

   // hold coefficients beside the root pipeline
   always_ff @(posedge clock) begin
      side_dly_ff[0] <= f_side;
      for (int i = 1; i < ROOT_BITS; i++) begin
         side_dly_ff[i] <= side_dly_ff[i-1];
      end
   end

   lci_back u_back (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (s_valid),
      .root      (s_root),
      .side      (side_dly_ff[ROOT_BITS-1]),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // a result never carries a count of three
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hit_count != 2'd3))
      else $error("invalid hit count");

   // no hit means all coordinates clear and no clipping
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit_count == HITS_NONE) |->
         (rsp_data.first_x == '0 && rsp_data.first_y == '0 &&
          rsp_data.second_x == '0 && rsp_data.second_y == '0 &&
          !rsp_data.saturated))
      else $error("coordinates reported without a hit");

   // a single hit leaves the second point clear
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit_count == HITS_ONE) |->
         (rsp_data.second_x == '0 && rsp_data.second_y == '0))
      else $error("second point reported on a tangent");

endmodule
